// ----- hw/rtl/tcb_pkg.sv -----
package tcb_pkg;

	localparam int COL_W    = 7;
	localparam int ROW_W    = 6;
	localparam int CODE_W   = 16;
	localparam int REP_W    = 8;
	localparam int OP_W     = 2;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 32;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int COLS_W   = 8;
	localparam int ROWS_W   = 7;

	localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
	localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd25;

	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
	localparam logic [OP_W-1:0] OP_KEY  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic [CODE_W-1:0] KEY_HOME  = 16'd0;
	localparam logic [CODE_W-1:0] KEY_END   = 16'd1;
	localparam logic [CODE_W-1:0] KEY_PGUP  = 16'd2;
	localparam logic [CODE_W-1:0] KEY_PGDN  = 16'd3;
	localparam logic [CODE_W-1:0] KEY_LEFT  = 16'd4;
	localparam logic [CODE_W-1:0] KEY_RIGHT = 16'd5;
	localparam logic [CODE_W-1:0] KEY_UP    = 16'd6;
	localparam logic [CODE_W-1:0] KEY_DOWN  = 16'd7;
	localparam logic [CODE_W-1:0] KEY_DEL   = 16'd8;

	localparam logic [CODE_W-1:0] CH_BS    = 16'h0008;
	localparam logic [CODE_W-1:0] CH_TAB   = 16'h0009;
	localparam logic [CODE_W-1:0] CH_LF    = 16'h000A;
	localparam logic [CODE_W-1:0] CH_CR    = 16'h000D;
	localparam logic [CODE_W-1:0] CH_ESC   = 16'h001B;
	localparam logic [CODE_W-1:0] CH_SPACE = 16'h0020;

endpackage

// ----- hw/rtl/tcb_cfg.sv -----
module tcb_cfg #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64,
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tcb_pkg::PADDR_W-1:0]  paddr,
	input  logic [tcb_pkg::PDATA_W-1:0]  pwdata,
	output logic [tcb_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [CW-1:0]                last_col,
	output logic [RW-1:0]                last_row
);
	import tcb_pkg::*;

	logic [COLS_W-1:0] cols_q;
	logic [ROWS_W-1:0] rows_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_COLS: cols_q <= pwdata[COLS_W-1:0];
				REG_ROWS: rows_q <= pwdata[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_COLS: prdata = PDATA_W'(cols_q);
			REG_ROWS: prdata = PDATA_W'(rows_q);
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		if (cols_q == '0) begin
			last_col = '0;
		end else if (int'(cols_q) > MAX_COLS) begin
			last_col = CW'(MAX_COLS - 1);
		end else begin
			last_col = CW'(int'(cols_q) - 1);
		end
		if (rows_q == '0) begin
			last_row = '0;
		end else if (int'(rows_q) > MAX_ROWS) begin
			last_row = RW'(MAX_ROWS - 1);
		end else begin
			last_row = RW'(int'(rows_q) - 1);
		end
	end

endmodule

// ----- hw/rtl/tcb_cell_mem.sv -----
module tcb_cell_mem #(
	parameter int DEPTH = 8192,
	parameter int DW    = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] cells [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			cells[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= cells[raddr];
		end
	end

endmodule

// ----- hw/rtl/tcb_seq.sv -----
module tcb_seq #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64,
	parameter int TAB_STOP = 8,
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int DEPTH = MAX_COLS * MAX_ROWS,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [CW-1:0]                 last_col,
	input  logic [RW-1:0]                 last_row,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tcb_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [tcb_pkg::OP_W-1:0]      s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tcb_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [tcb_pkg::CODE_W-1:0]    mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr,
	input  logic [tcb_pkg::CODE_W-1:0]    mem_rdata
);
	import tcb_pkg::*;

	typedef enum logic [6:0] {
		ST_CLR    = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_DISP   = 7'b0000100,
		ST_CHAR   = 7'b0001000,
		ST_DEL_RD = 7'b0010000,
		ST_DEL_WR = 7'b0100000,
		ST_FIN    = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic                esc_q;
	logic [CW-1:0]       col_q;
	logic [RW-1:0]       row_q;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_data_q;

	logic [OP_W-1:0]     op_q;
	logic [CODE_W-1:0]   code_q;
	logic [REP_W-1:0]    rep_q;
	logic [AW-1:0]       rd_addr_q;
	logic                rd_ok_q;
	logic [CW-1:0]       x_q;

	logic [MAX_COLS-1:0] tab_hit;
	logic [CW-1:0]       adv_col;
	logic [RW-1:0]       adv_row;
	logic [RW-1:0]       row_next;
	logic                consume;
	logic                out_free;
	logic [CODE_W-1:0]   cell_val;

	function automatic logic [AW-1:0] cell_addr(input int r, input int c);
		return AW'(r * MAX_COLS + c);
	endfunction

	for (genvar g = 0; g < MAX_COLS; g++) begin : g_tab
		assign tab_hit[g] = ((g % TAB_STOP) == 0);
	end

	assign row_next = (row_q == last_row) ? '0 : row_q + 1'b1;
	assign adv_col  = (col_q == last_col) ? '0 : col_q + 1'b1;
	assign adv_row  = (col_q == last_col) ? row_next : row_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign cell_val = (op_q == OP_READ && rd_ok_q) ? mem_rdata : '0;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

	always_comb begin
		consume = 1'b0;
		if (state_q == ST_CHAR) begin
			case (code_q)
				CH_BS:   consume = (col_q == '0);
				CH_TAB:  consume = tab_hit[adv_col];
				CH_ESC:  consume = 1'b0;
				default: consume = 1'b1;
			endcase
		end else if (state_q == ST_DEL_RD) begin
			consume = (x_q == last_col) && (op_q == OP_CHAR);
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr(int'(row_q), int'(col_q));
		mem_wdata = CH_SPACE;
		mem_re    = 1'b0;
		mem_raddr = rd_addr_q;
		unique case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_DISP: begin
				mem_re = (op_q == OP_READ) && rd_ok_q;
			end
			ST_CHAR: begin
				case (code_q) inside
					CH_BS, CH_LF, CH_CR, CH_ESC: mem_we = 1'b0;
					CH_TAB: mem_we = 1'b1;
					default: begin
						mem_we    = 1'b1;
						mem_wdata = code_q;
					end
				endcase
			end
			ST_DEL_RD: begin
				if (x_q == last_col) begin
					mem_we    = 1'b1;
					mem_waddr = cell_addr(int'(row_q), int'(last_col));
				end else begin
					mem_re    = 1'b1;
					mem_raddr = cell_addr(int'(row_q), int'(x_q) + 1);
				end
			end
			ST_DEL_WR: begin
				mem_we    = 1'b1;
				mem_waddr = cell_addr(int'(row_q), int'(x_q));
				mem_wdata = mem_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			esc_q      <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						clr_q   <= '0;
						state_q <= esc_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						col_q   <= (col_q > last_col) ? last_col : col_q;
						row_q   <= (row_q > last_row) ? last_row : row_q;
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					state_q <= ST_FIN;
					case (op_q)
						OP_CHAR: begin
							if (rep_q != '0) begin
								state_q <= ST_CHAR;
							end
						end
						OP_KEY: begin
							case (code_q)
								KEY_HOME:  col_q <= '0;
								KEY_END:   col_q <= last_col;
								KEY_PGUP:  row_q <= '0;
								KEY_PGDN:  row_q <= last_row;
								KEY_LEFT:  if (col_q != '0) col_q <= col_q - 1'b1;
								KEY_RIGHT: if (col_q != last_col) col_q <= col_q + 1'b1;
								KEY_UP:    if (row_q != '0) row_q <= row_q - 1'b1;
								KEY_DOWN:  if (row_q != last_row) row_q <= row_q + 1'b1;
								KEY_DEL:   state_q <= ST_DEL_RD;
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				ST_CHAR: begin
					case (code_q)
						CH_BS: begin
							if (col_q != '0) begin
								col_q   <= col_q - 1'b1;
								state_q <= ST_DEL_RD;
							end
						end
						CH_LF: row_q <= row_next;
						CH_CR: begin
							col_q <= '0;
							row_q <= row_next;
						end
						CH_ESC: begin
							col_q   <= '0;
							row_q   <= '0;
							clr_q   <= '0;
							esc_q   <= 1'b1;
							state_q <= ST_CLR;
						end
						default: begin
							col_q <= adv_col;
							row_q <= adv_row;
						end
					endcase
				end
				ST_DEL_RD: begin
					state_q <= (x_q == last_col) ? ST_FIN : ST_DEL_WR;
				end
				ST_DEL_WR: begin
					state_q <= ST_DEL_RD;
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (consume) begin
				state_q <= (rep_q == REP_W'(1)) ? ST_FIN : ST_CHAR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q      <= s_tuser;
			code_q    <= s_tdata[15:0];
			rep_q     <= s_tdata[23:16];
			rd_ok_q   <= (int'(s_tdata[36:31]) < MAX_ROWS) && (int'(s_tdata[30:24]) < MAX_COLS);
			rd_addr_q <= cell_addr(int'(s_tdata[36:31]), int'(s_tdata[30:24]));
		end
		if (consume) begin
			rep_q <= rep_q - 1'b1;
		end
		if (state_q == ST_DISP) begin
			x_q <= col_q;
		end
		if (state_q == ST_CHAR) begin
			x_q <= col_q - 1'b1;
		end
		if (state_q == ST_DEL_WR) begin
			x_q <= x_q + 1'b1;
		end
		if (state_q == ST_FIN && out_free) begin
			m_data_q <= {3'b000, cell_val, ROW_W'(row_q), COL_W'(col_q)};
		end
	end

endmodule

// ----- hw/rtl/text_cell_buffer_with_caret_unit.sv -----
// A read, a key or an empty character beat passes ST_DISP and ST_FIN, which waits for a free
// output. A character beat visits ST_CHAR per application, a tab per space written instead;
// a delete or a backspace alternates ST_DEL_RD and ST_DEL_WR per cell shifted, then
// ST_DEL_RD blanks the last column in use. Escape sweeps every cell once in ST_CLR. One beat
// is in work at a time. Reset: caret to (0,0), sizes to 80x25, then a clearing pass writes
// spaces while s_tready stays low; configuration writes are taken throughout.
module text_cell_buffer_with_caret_unit #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64,
	parameter int TAB_STOP = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tcb_pkg::PADDR_W-1:0]   paddr,
	input  logic [tcb_pkg::PDATA_W-1:0]   pwdata,
	output logic [tcb_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// code[15:0], repeat_req[23:16], read_col[30:24], read_row[36:31], zero[39:37]
	input  logic [tcb_pkg::S_DATA_W-1:0]  s_tdata,
	// op[1:0]
	input  logic [tcb_pkg::OP_W-1:0]      s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// caret_col[6:0], caret_row[12:7], cell_value[28:13], zero[31:29]
	output logic [tcb_pkg::M_DATA_W-1:0]  m_tdata
);
	import tcb_pkg::*;

	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CW-1:0]     last_col;
	logic [RW-1:0]     last_row;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CODE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [CODE_W-1:0] mem_rdata;

	tcb_cfg #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.last_col (last_col),
		.last_row (last_row)
	);

	tcb_cell_mem #(
		.DEPTH (DEPTH),
		.DW    (CODE_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tcb_seq #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.TAB_STOP (TAB_STOP)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.last_col  (last_col),
		.last_row  (last_row),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

// ----- hw/rtl/tcb_checker.sv -----
module tcb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tcb_pkg::M_DATA_W-1:0]  m_tdata
);
	import tcb_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !s_tready && !m_tvalid)
		else $error("handshake active during reset");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat taken while one is in work");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result raised in the cycle after accept");

endmodule

bind text_cell_buffer_with_caret_unit tcb_checker u_chk (.*);
